### hdl/pid_loop_clamped_integrator_defines.svh
// Assertion macros shared by the RTL.
`ifndef PID_LOOP_CLAMPED_INTEGRATOR_DEFINES_SVH
`define PID_LOOP_CLAMPED_INTEGRATOR_DEFINES_SVH

// Same-cycle implication.
`define PLC_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PLC_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/plc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;
  localparam int STATUS_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_UPPER = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_LOWER = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TARGET      = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_STEP = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd2;

  // shared shift-add / restoring-divide unit
  localparam int MCAND_W  = 49;                 // multiplicand magnitude
  localparam int MPLIER_W = 33;                 // multiplier magnitude
  localparam int PROD_W   = MCAND_W + MPLIER_W;
  localparam int DVD_W    = 64;                 // dividend / quotient
  localparam int REM_W    = DATA_W + 1;
  localparam int WORK_W   = REM_W + DVD_W;
  localparam int ADD_W    = MCAND_W + 1;
  localparam int CNT_W    = 7;

  localparam logic [CNT_W-1:0] MUL_STEPS = 7'(MPLIER_W);
  localparam logic [CNT_W-1:0] DIV_STEPS = 7'(DVD_W);

  typedef struct packed {
    logic start;
    logic div_mode;
  } plc_cmd_t;

endpackage

`default_nettype wire

### hdl/plc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface plc_in_if import plc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] measured;
  logic        [DATA_W-1:0] time_step;

  modport source (output valid, output measured, output time_step, input ready);
  modport sink   (input valid, input measured, input time_step, output ready);
endinterface

`default_nettype wire

### hdl/plc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface plc_out_if import plc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output drive, output status, input ready);
  modport sink   (input valid, input drive, input status, output ready);
endinterface

`default_nettype wire

### hdl/pid_loop_clamped_integrator.sv
// A normal item runs through the shared shift-add / restoring-divide unit: four 33-step
//   multiplies and one 64-step divide. The first item after reset uses only the
//   proportional multiply, and a zero time step after the first item goes straight to a
//   bad-step result. A new input beat is taken only in idle, once the last item is emitted.
// Reset (rst, synchronous): registers to their defaults, integrator and last measurement
//   to zero, controller unstarted, no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_loop_clamped_integrator_defines.svh"

module pid_loop_clamped_integrator import plc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  plc_in_if.sink                    sample,
  plc_out_if.source                 response,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL_P = 4'd1;
  localparam logic [3:0] ST_MUL_T = 4'd2;
  localparam logic [3:0] ST_MUL_I = 4'd3;
  localparam logic [3:0] ST_CLAMP = 4'd4;
  localparam logic [3:0] ST_MUL_D = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_SUM   = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  localparam int SP_W  = PROD_W + 1;
  localparam int TOT_W = 54;

  localparam logic signed [SP_W-1:0]  INC_CAP   = 83'sd1099511627776;   // 2^40
  localparam logic signed [SP_W-1:0]  INC_FLOOR = -83'sd1099511627776;
  localparam logic [DVD_W-1:0]        D_CAP     = 64'd1125899906842624;  // 2^50
  localparam logic signed [TOT_W-1:0] DRV_MAX   = 54'sd2147483647;
  localparam logic signed [TOT_W-1:0] DRV_MIN   = -54'sd2147483648;

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  function automatic logic [DATA_W:0] mag33(input logic [DATA_W:0] v);
    return v[DATA_W] ? (~v + (DATA_W+1)'(1)) : v;
  endfunction

  function automatic logic [MCAND_W-1:0] mag49(input logic [MCAND_W-1:0] v);
    return v[MCAND_W-1] ? (~v + MCAND_W'(1)) : v;
  endfunction

  // {status, drive} with saturation to 32 bits
  function automatic logic [STATUS_W+DATA_W-1:0] sat_drive(
      input logic signed [TOT_W-1:0] v);
    logic [STATUS_W+DATA_W-1:0] r;
    if (v > DRV_MAX) begin
      r = {STATUS_SAT, DRV_MAX[DATA_W-1:0]};
    end else if (v < DRV_MIN) begin
      r = {STATUS_SAT, DRV_MIN[DATA_W-1:0]};
    end else begin
      r = {STATUS_OK, v[DATA_W-1:0]};
    end
    return r;
  endfunction

  // configuration
  logic signed [DATA_W-1:0] prop_gain;
  logic signed [DATA_W-1:0] integ_gain;
  logic signed [DATA_W-1:0] deriv_gain;
  logic signed [DATA_W-1:0] integ_upper;
  logic signed [DATA_W-1:0] integ_lower;
  logic signed [DATA_W-1:0] target;

  // controller state
  logic                     started;
  logic signed [DATA_W-1:0] integrator;
  logic signed [DATA_W-1:0] previous_measured;

  // sequencer and item working registers
  logic [3:0]                  state;
  logic                        launched;
  logic signed [DATA_W-1:0]    meas_r;
  logic [DATA_W-1:0]           ts_r;
  logic signed [DATA_W:0]      err_r;
  logic signed [DATA_W:0]      delta_r;
  logic signed [MCAND_W-1:0]   p_r;
  logic signed [MCAND_W-1:0]   t_r;
  logic signed [41:0]          inc_r;
  logic [DVD_W-1:0]            dm_r;
  logic signed [51:0]          d_r;
  logic [DATA_W-1:0]           res_drive;
  logic [STATUS_W-1:0]         res_status;

  // output register
  logic                        out_valid;
  logic [DATA_W-1:0]           out_drive;
  logic [STATUS_W-1:0]         out_status;

  // shared unit
  plc_cmd_t                    unit_cmd;
  logic [MCAND_W-1:0]          unit_opa;
  logic [DVD_W-1:0]            unit_opb;
  logic                        unit_done;
  logic [PROD_W-1:0]           unit_prod;
  logic [DVD_W-1:0]            unit_quot;

  // datapath around the unit
  logic                        prod_neg;
  logic signed [SP_W-1:0]      prod_ext;
  logic signed [SP_W-1:0]      sprod;
  logic signed [SP_W-1:0]      sh;
  logic signed [41:0]          inc_sat;
  logic signed [42:0]          acc;
  logic signed [42:0]          upper_ext;
  logic signed [42:0]          lower_ext;
  logic signed [DATA_W-1:0]    clamp_val;
  logic [50:0]                 dmag;
  logic signed [51:0]          d_next;
  logic signed [TOT_W-1:0]     total;
  logic [STATUS_W+DATA_W-1:0]  sat_p;
  logic [STATUS_W+DATA_W-1:0]  sat_total;

  plc_iter_unit u_iter (
    .clk  (clk),
    .rst  (rst),
    .cmd  (unit_cmd),
    .opa  (unit_opa),
    .opb  (unit_opb),
    .done (unit_done),
    .prod (unit_prod),
    .quot (unit_quot)
  );

  always_comb begin
    unit_cmd.start    = 1'b0;
    unit_cmd.div_mode = (state == ST_DIV);
    unit_opa          = '0;
    unit_opb          = '0;
    case (state)
      ST_MUL_P: begin
        unit_opa = MCAND_W'(mag32(prop_gain));
        unit_opb = DVD_W'(mag33(err_r));
      end
      ST_MUL_T: begin
        unit_opa = MCAND_W'(mag32(integ_gain));
        unit_opb = DVD_W'(mag33(err_r));
      end
      ST_MUL_I: begin
        unit_opa = mag49(t_r);
        unit_opb = DVD_W'(ts_r);
      end
      ST_MUL_D: begin
        unit_opa = MCAND_W'(mag32(deriv_gain));
        unit_opb = DVD_W'(mag33(delta_r));
      end
      ST_DIV: begin
        unit_opa = MCAND_W'(ts_r);
        unit_opb = dm_r;
      end
      default: begin
        unit_opa = '0;
        unit_opb = '0;
      end
    endcase
    if ((state == ST_MUL_P || state == ST_MUL_T || state == ST_MUL_I ||
         state == ST_MUL_D || state == ST_DIV) && !launched) begin
      unit_cmd.start = 1'b1;
    end
  end

  always_comb begin
    case (state)
      ST_MUL_P: prod_neg = prop_gain[DATA_W-1] ^ err_r[DATA_W];
      ST_MUL_T: prod_neg = integ_gain[DATA_W-1] ^ err_r[DATA_W];
      ST_MUL_I: prod_neg = t_r[MCAND_W-1];
      default:  prod_neg = 1'b0;
    endcase
    prod_ext = {1'b0, unit_prod};
    sprod    = prod_neg ? -prod_ext : prod_ext;
    sh       = sprod >>> 16;    // floor divide by 2^16

    if (sh > INC_CAP) begin
      inc_sat = INC_CAP[41:0];
    end else if (sh < INC_FLOOR) begin
      inc_sat = INC_FLOOR[41:0];
    end else begin
      inc_sat = sh[41:0];
    end

    acc       = {{11{integrator[DATA_W-1]}}, integrator} + {inc_r[41], inc_r};
    upper_ext = {{11{integ_upper[DATA_W-1]}}, integ_upper};
    lower_ext = {{11{integ_lower[DATA_W-1]}}, integ_lower};
    // when the bounds cross: upper bound if the sum is above it, else lower bound
    if (acc > upper_ext) begin
      clamp_val = integ_upper;
    end else if (acc < lower_ext) begin
      clamp_val = integ_lower;
    end else begin
      clamp_val = acc[DATA_W-1:0];
    end

    dmag   = (unit_quot > D_CAP) ? D_CAP[50:0] : unit_quot[50:0];
    d_next = (deriv_gain[DATA_W-1] ^ delta_r[DATA_W]) ? -{1'b0, dmag} : {1'b0, dmag};

    total = {{5{p_r[MCAND_W-1]}}, p_r}
          + {{22{integrator[DATA_W-1]}}, integrator}
          - {{2{d_r[51]}}, d_r};

    sat_p     = sat_drive({{5{sh[MCAND_W-1]}}, sh[MCAND_W-1:0]});
    sat_total = sat_drive(total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      integ_upper <= 32'sh7FFF_FFFF;
      integ_lower <= 32'sh8000_0000;
      target      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:   prop_gain   <= $signed(cfg_data);
        REG_INTEG_GAIN:  integ_gain  <= $signed(cfg_data);
        REG_DERIV_GAIN:  deriv_gain  <= $signed(cfg_data);
        REG_INTEG_UPPER: integ_upper <= $signed(cfg_data);
        REG_INTEG_LOWER: integ_lower <= $signed(cfg_data);
        REG_TARGET:      target      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      launched          <= 1'b0;
      started           <= 1'b0;
      integrator        <= '0;
      previous_measured <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (response.ready) out_valid <= 1'b0;
      if (unit_cmd.start) launched <= 1'b1;
      if (unit_done) launched <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            meas_r  <= sample.measured;
            ts_r    <= sample.time_step;
            err_r   <= {target[DATA_W-1], target}
                     - {sample.measured[DATA_W-1], sample.measured};
            delta_r <= {sample.measured[DATA_W-1], sample.measured}
                     - {previous_measured[DATA_W-1], previous_measured};
            if (started && sample.time_step == '0) begin
              res_drive  <= '0;
              res_status <= STATUS_BAD_STEP;
              state      <= ST_EMIT;
            end else begin
              state <= ST_MUL_P;
            end
          end
        end
        ST_MUL_P: begin
          if (unit_done) begin
            p_r <= sh[MCAND_W-1:0];
            if (!started) begin
              // first beat: proportional term only
              started                 <= 1'b1;
              previous_measured       <= meas_r;
              {res_status, res_drive} <= sat_p;
              state                   <= ST_EMIT;
            end else begin
              state <= ST_MUL_T;
            end
          end
        end
        ST_MUL_T: begin
          if (unit_done) begin
            t_r   <= sh[MCAND_W-1:0];
            state <= ST_MUL_I;
          end
        end
        ST_MUL_I: begin
          if (unit_done) begin
            inc_r <= inc_sat;
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          integrator <= clamp_val;
          state      <= ST_MUL_D;
        end
        ST_MUL_D: begin
          if (unit_done) begin
            dm_r  <= unit_prod[DVD_W-1:0];
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (unit_done) begin
            d_r   <= d_next;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          {res_status, res_drive} <= sat_total;
          previous_measured       <= meas_r;
          state                   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || response.ready) begin
            out_valid  <= 1'b1;
            out_drive  <= res_drive;
            out_status <= res_status;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign sample.ready    = (state == ST_IDLE);
  assign response.valid  = out_valid;
  assign response.drive  = out_drive;
  assign response.status = out_status;

  `PLC_ASSERT_NEXT(a_integ_clamped, clk, rst, state == ST_CLAMP && integ_lower <= integ_upper,
                   integrator <= $past(integ_upper) && integrator >= $past(integ_lower),
                   "integrator outside clamp")
  `PLC_ASSERT_NOW(a_bad_step_zero, clk, rst, out_valid && out_status == STATUS_BAD_STEP,
                  out_drive == '0, "nonzero drive on bad time step")
  `PLC_ASSERT_NOW(a_load_from_emit, clk, rst, $rose(out_valid), $past(state) == ST_EMIT,
                  "result loaded outside emit")
  `PLC_ASSERT_NOW(a_done_when_launched, clk, rst, unit_done, launched,
                  "unit done with no operation launched")

endmodule

`default_nettype wire

### hdl/plc_iter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "pid_loop_clamped_integrator_defines.svh"

module plc_iter_unit import plc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire plc_cmd_t           cmd,
  input  wire logic [MCAND_W-1:0] opa,   // multiplicand, or divisor in low bits
  input  wire logic [DVD_W-1:0]   opb,   // multiplier in low bits, or dividend
  output logic                    done,
  output logic [PROD_W-1:0]       prod,
  output logic [DVD_W-1:0]        quot
);

  logic               busy;
  logic               div_mode;
  logic [CNT_W-1:0]   cnt;
  logic [WORK_W-1:0]  work;
  logic [MCAND_W-1:0] opa_r;

  logic [ADD_W-1:0]   add_a;
  logic [ADD_W-1:0]   add_b;
  logic [ADD_W-1:0]   sum;
  logic               borrow;
  logic [REM_W-1:0]   rem_new;
  logic [WORK_W-1:0]  work_next;

  // one adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    if (div_mode) begin
      add_a = {(ADD_W-REM_W)'(0), work[WORK_W-2 -: REM_W]};
      add_b = ADD_W'(opa_r[DATA_W-1:0]);
      sum   = add_a - add_b;
    end else begin
      add_a = {1'b0, work[PROD_W-1:MPLIER_W]};
      add_b = work[0] ? {1'b0, opa_r} : '0;
      sum   = add_a + add_b;
    end
    borrow = sum[ADD_W-1];
    if (div_mode) begin
      rem_new   = borrow ? work[WORK_W-2 -: REM_W] : sum[REM_W-1:0];
      work_next = {rem_new, work[DVD_W-2:0], ~borrow};
    end else begin
      rem_new   = '0;
      work_next = {(WORK_W-PROD_W)'(0), sum, work[MPLIER_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      div_mode <= 1'b0;
      cnt      <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy     <= 1'b1;
        div_mode <= cmd.div_mode;
        cnt      <= cmd.div_mode ? DIV_STEPS : MUL_STEPS;
        opa_r    <= opa;
        work     <= cmd.div_mode ? {REM_W'(0), opb}
                                 : {(WORK_W-MPLIER_W)'(0), opb[MPLIER_W-1:0]};
      end else if (busy) begin
        work <= work_next;
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = work[PROD_W-1:0];
  assign quot = work[DVD_W-1:0];

  `PLC_ASSERT_NOW(a_no_restart, clk, rst, cmd.start, !busy, "start while busy")
  `PLC_ASSERT_NOW(a_done_after_busy, clk, rst, done, $past(busy), "done without work")
  `PLC_ASSERT_NOW(a_mul_count, clk, rst, busy && !div_mode, cnt <= MUL_STEPS,
                  "multiply count overrun")
  `PLC_ASSERT_NEXT(a_busy_after_start, clk, rst, cmd.start, busy && !done,
                   "start not taken")

endmodule

`default_nettype wire
